FILE: sv/nqct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqct_pkg: shared types and constants of the queue command ID tracker
// Field widths, opcode/action/register codes, the queued item and the
// control structs that pass between the front, back and register blocks.
// ----------------------------------------------------------------------------
package nqct_pkg;

	localparam int ID_W            = 16;
	localparam int ID_SPACE        = 65536;
	localparam int ROW_W           = 64;
	localparam int ROW_BITS        = $clog2(ROW_W);
	localparam int ROWS            = ID_SPACE / ROW_W;
	localparam int ROW_AW          = $clog2(ROWS);
	localparam int QSIZE_W         = 17;
	localparam int HEAD_W          = 16;
	localparam int STATUS_W        = 12;
	localparam int ACTION_W        = 3;
	localparam int CHECK_W         = 8;
	localparam int STYPE_W         = 3;
	localparam int SVAL_W          = 8;
	localparam int OP_W            = 2;
	localparam int APB_DW          = 32;
	localparam int REG_AW          = 5;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam logic [STYPE_W-1:0] SCT_GENERIC    = 3'd0;
	localparam logic [SVAL_W-1:0]  SC_ID_CONFLICT = 8'h03;

	typedef enum logic [OP_W-1:0] {
		OP_ARRIVE,
		OP_COMPLETE,
		OP_RELEASE,
		OP_NONE
	} op_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_DROP,
		ACT_FWD_ADMIN,
		ACT_FWD_IO,
		ACT_RESP,
		ACT_NOT_CONN,
		ACT_RELEASED
	} action_t;

	typedef enum logic [2:0] {
		REG_CTRL,
		REG_LINK,
		REG_ADMIN,
		REG_FLOW,
		REG_QSIZE,
		REG_QNUM,
		REG_HEAD
	} reg_idx_t;

	typedef struct packed {
		op_t                op;
		logic [ID_W-1:0]    id;
		logic [CHECK_W-1:0] check_code;
		logic [STYPE_W-1:0] status_type;
		logic [SVAL_W-1:0]  status_value;
	} item_t;

	typedef struct packed {
		logic               attached;
		logic               link;
		logic               admin;
		logic               flow;
		logic [QSIZE_W-1:0] qsize;
		logic [HEAD_W-1:0]  qnum;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [HEAD_W-1:0] value;
	} head_load_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} f2b_t;

	typedef struct packed {
		logic pop;
		logic init_done;
	} b2f_t;

	function automatic logic [STATUS_W-1:0] pack_status(
		input logic [STYPE_W-1:0] sct,
		input logic [SVAL_W-1:0]  sc
	);
		return {sct, sc, 1'b0};
	endfunction

endpackage

FILE: sv/nqct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqct_if: command and result channels
// Valid/ready channels carrying one command or completion in, one result out.
// ----------------------------------------------------------------------------
interface nqct_in_if;
	import nqct_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [ID_W-1:0]    command_id;
	logic [CHECK_W-1:0] check_code;
	logic [STYPE_W-1:0] status_type;
	logic [SVAL_W-1:0]  status_value;

	modport source (output valid, opcode, command_id, check_code, status_type, status_value,
		input ready);
	modport sink (input valid, opcode, command_id, check_code, status_type, status_value,
		output ready);
endinterface

interface nqct_out_if;
	import nqct_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ID_W-1:0]     resp_id;
	logic [STATUS_W-1:0] resp_status;
	logic [HEAD_W-1:0]   resp_head;
	logic [HEAD_W-1:0]   fwd_queue;
	logic                id_was_free;

	modport source (output valid, action, resp_id, resp_status, resp_head, fwd_queue,
		id_was_free, input ready);
	modport sink (input valid, action, resp_id, resp_status, resp_head, fwd_queue,
		id_was_free, output ready);
endinterface

FILE: sv/nvme_queue_cid_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvme_queue_cid_tracker: per-queue command ID tracker
// Marks 16-bit command IDs busy on arrival, frees them on completion or release and
// keeps the submission head reported in responses.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready channel of arrivals (opcode 0), completions with
//            response (1) and releases (2); opcode 3 is taken and ignored.
//   out_ch : valid/ready channel with one result per non-ignored command.
//   APB    : configuration registers at byte address 4*index; write them
//            only while no transaction is in flight.
// After reset the busy-bit memory (1024 rows of 64 bits) is cleared one row
// per cycle, and in_ch.ready stays low until that pass has finished.
// Each non-ignored command is queued in a 2-entry FIFO; the back end then
// reads its busy-bit row (S_IDLE), then decides, writes the row back and
// registers the result (S_EXEC). It takes the next command only after
// that, so commands are handled one at a time. A response that must fold
// a head that lies beyond queue_size first runs a bit-serial remainder.
// When out_ch stalls the result register holds, the back end waits, and the
// FIFO keeps taking commands until it is full.
// ----------------------------------------------------------------------------
module nvme_queue_cid_tracker #(
	parameter int QUEUE_DEPTH = nqct_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	nqct_in_if.sink                     in_ch,
	nqct_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nqct_pkg::REG_AW-1:0] paddr,
	input  logic [nqct_pkg::APB_DW-1:0] pwdata,
	output logic [nqct_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import nqct_pkg::*;

	cfg_t       cfg;
	head_load_t head_load;
	f2b_t       f2b;
	b2f_t       b2f;

	nqct_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.head_load (head_load)
	);

	nqct_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.b2f    (b2f),
		.f2b    (f2b)
	);

	nqct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head_load (head_load),
		.f2b       (f2b),
		.b2f       (b2f),
		.out_ch    (out_ch)
	);

	// no transaction may enter before the clearing pass has finished
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> b2f.init_done)
		else $error("command accepted during busy-bit clearing");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		b2f.pop |-> f2b.valid)
		else $error("back end popped an empty queue");

	a_not_conn_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.action == ACT_NOT_CONN)) |-> (out_ch.resp_head == '0))
		else $error("not-connected result reports a head");

	a_forward_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.action == ACT_FWD_ADMIN || out_ch.action == ACT_FWD_IO))
		|-> (out_ch.resp_status == '0 && !out_ch.id_was_free))
		else $error("forwarded command carries status or free flag");

endmodule

FILE: sv/nqct_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqct_regs: APB configuration registers
// Holds queue configuration; a write of the start head also loads the
// submission head counter in the back end.
// ----------------------------------------------------------------------------
module nqct_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nqct_pkg::REG_AW-1:0]  paddr,
	input  logic [nqct_pkg::APB_DW-1:0]  pwdata,
	output logic [nqct_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output nqct_pkg::cfg_t               cfg,
	output nqct_pkg::head_load_t         head_load
);
	import nqct_pkg::*;

	logic              attached_q;
	logic              link_q;
	logic              admin_q;
	logic              flow_q;
	logic [QSIZE_W-1:0] qsize_q;
	logic [HEAD_W-1:0] qnum_q;
	logic [HEAD_W-1:0] start_head_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[REG_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attached_q   <= 1'b0;
			link_q       <= 1'b0;
			admin_q      <= 1'b0;
			flow_q       <= 1'b0;
			qsize_q      <= QSIZE_W'(1);
			qnum_q       <= '0;
			start_head_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CTRL:  attached_q   <= pwdata[0];
				REG_LINK:  link_q       <= pwdata[0];
				REG_ADMIN: admin_q      <= pwdata[0];
				REG_FLOW:  flow_q       <= pwdata[0];
				REG_QSIZE: qsize_q      <= pwdata[QSIZE_W-1:0];
				REG_QNUM:  qnum_q       <= pwdata[HEAD_W-1:0];
				REG_HEAD:  start_head_q <= pwdata[HEAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CTRL:  prdata = APB_DW'(attached_q);
			REG_LINK:  prdata = APB_DW'(link_q);
			REG_ADMIN: prdata = APB_DW'(admin_q);
			REG_FLOW:  prdata = APB_DW'(flow_q);
			REG_QSIZE: prdata = APB_DW'(qsize_q);
			REG_QNUM:  prdata = APB_DW'(qnum_q);
			REG_HEAD:  prdata = APB_DW'(start_head_q);
			default:   prdata = '0;
		endcase
	end

	assign cfg.attached = attached_q;
	assign cfg.link     = link_q;
	assign cfg.admin    = admin_q;
	assign cfg.flow     = flow_q;
	assign cfg.qsize    = qsize_q;
	assign cfg.qnum     = qnum_q;

	assign head_load.valid = wr_en && (idx == REG_HEAD);
	assign head_load.value = pwdata[HEAD_W-1:0];

endmodule

FILE: sv/nqct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqct_front: command intake and classification
// Accepts transactions, drops the unused opcode and queues the rest for
// the back end in a small FIFO.
// ----------------------------------------------------------------------------
module nqct_front #(
	parameter int QUEUE_DEPTH = nqct_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	nqct_in_if.sink        in_ch,
	input  nqct_pkg::b2f_t b2f,
	output nqct_pkg::f2b_t f2b
);
	import nqct_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	item_t              in_item;
	logic               push;
	logic               pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign in_item.op           = op_t'(in_ch.opcode);
	assign in_item.id           = in_ch.command_id;
	assign in_item.check_code   = in_ch.check_code;
	assign in_item.status_type  = in_ch.status_type;
	assign in_item.status_value = in_ch.status_value;

	assign in_ch.ready = b2f.init_done && (count_q != CNT_W'(QUEUE_DEPTH));
	// the unused opcode is taken and discarded without a result
	assign push = in_ch.valid && in_ch.ready && (in_item.op != OP_NONE);
	assign pop  = b2f.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= in_item;
	end

	assign f2b.valid = (count_q != '0);
	assign f2b.item  = entry_q[rd_ptr_q];

endmodule

FILE: sv/nqct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqct_back: busy-bit store and command execution
// Clears the busy-bit memory after reset, then per item reads the ID row,
// decides the outcome, writes the row back and registers the result.
// Head wrap from an out-of-range head runs a bit-serial remainder.
// ----------------------------------------------------------------------------
module nqct_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nqct_pkg::cfg_t       cfg,
	input  nqct_pkg::head_load_t head_load,
	input  nqct_pkg::f2b_t       f2b,
	output nqct_pkg::b2f_t       b2f,
	nqct_out_if.source           out_ch
);
	import nqct_pkg::*;

	localparam int MOD_CNT_W = $clog2(QSIZE_W);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_MOD
	} state_t;

	logic [ROW_W-1:0]    mem [ROWS];
	logic [ROW_W-1:0]    rd_row_q;
	logic                mem_we;
	logic                mem_re;
	logic [ROW_AW-1:0]   mem_waddr;
	logic [ROW_W-1:0]    mem_wdata;

	state_t              state_q;
	logic [ROW_AW-1:0]   clr_cnt_q;
	logic [HEAD_W-1:0]   sub_head_q;
	logic                out_valid_q;
	action_t             out_action_q;
	logic [ID_W-1:0]     out_id_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [HEAD_W-1:0]   out_head_q;
	logic [HEAD_W-1:0]   out_fwd_q;
	logic                out_free_q;
	logic [QSIZE_W-1:0]  mod_rem_q;
	logic [QSIZE_W-1:0]  mod_div_q;
	logic [MOD_CNT_W-1:0] mod_cnt_q;

	item_t               item;
	logic [ROW_BITS-1:0] bit_idx;
	logic [ROW_AW-1:0]   row_idx;
	logic                was_busy;
	logic                out_free;
	logic [QSIZE_W-1:0]  qs_eff;
	logic [QSIZE_W-1:0]  head_inc;
	logic [QSIZE_W-1:0]  head_diff;
	logic [QSIZE_W:0]    rem_sh;
	logic [QSIZE_W:0]    rem_nx;

	action_t             x_action;
	logic [STATUS_W-1:0] x_status;
	logic [HEAD_W-1:0]   x_head;
	logic [HEAD_W-1:0]   x_fwd;
	logic                x_free;
	logic                x_respond;
	logic                x_advance;
	logic                x_need_mod;
	logic [ROW_W-1:0]    x_row;

	assign item     = f2b.item;
	assign bit_idx  = item.id[ROW_BITS-1:0];
	assign row_idx  = item.id[ID_W-1:ROW_BITS];
	assign was_busy = rd_row_q[bit_idx];
	assign out_free = !out_valid_q || out_ch.ready;

	// a queue size of zero stands for the full 16-bit range
	assign qs_eff    = (cfg.qsize == '0) ? QSIZE_W'(ID_SPACE) : cfg.qsize;
	assign head_inc  = {1'b0, sub_head_q} + QSIZE_W'(1);
	assign head_diff = head_inc - qs_eff;

	assign rem_sh = {mod_rem_q, mod_div_q[QSIZE_W-1]};
	assign rem_nx = (rem_sh >= {1'b0, qs_eff}) ? rem_sh - {1'b0, qs_eff} : rem_sh;

	always_comb begin
		x_action   = ACT_DROP;
		x_status   = '0;
		x_fwd      = '0;
		x_free     = 1'b0;
		x_respond  = 1'b0;
		x_row      = rd_row_q;
		unique case (item.op)
			OP_ARRIVE: begin
				if (!cfg.attached) begin
					x_action = ACT_DROP;
				end else if (item.check_code != '0) begin
					x_respond = 1'b1;
					x_status  = pack_status(SCT_GENERIC, item.check_code);
				end else if (was_busy) begin
					x_respond = 1'b1;
					x_status  = pack_status(SCT_GENERIC, SC_ID_CONFLICT);
				end else begin
					x_row[bit_idx] = 1'b1;
					x_action = cfg.admin ? ACT_FWD_ADMIN : ACT_FWD_IO;
					x_fwd    = cfg.admin ? '0 : cfg.qnum;
				end
			end
			OP_COMPLETE: begin
				x_free         = !was_busy;
				x_row[bit_idx] = 1'b0;
				x_respond      = 1'b1;
				x_status       = pack_status(item.status_type, item.status_value);
			end
			OP_RELEASE: begin
				x_free         = !was_busy;
				x_row[bit_idx] = 1'b0;
				x_action       = ACT_RELEASED;
			end
			default: ;
		endcase

		x_advance  = 1'b0;
		x_need_mod = 1'b0;
		x_head     = '0;
		if (x_respond) begin
			if (!cfg.link) begin
				x_action = ACT_NOT_CONN;
			end else begin
				x_action  = ACT_RESP;
				x_advance = cfg.flow;
			end
		end
		if (x_advance) begin
			if (head_inc < qs_eff)
				x_head = head_inc[HEAD_W-1:0];
			else if (head_diff < qs_eff)
				x_head = head_diff[HEAD_W-1:0];
			else
				x_need_mod = 1'b1;
		end
	end

	assign mem_we    = (state_q == S_CLEAR) || ((state_q == S_EXEC) && out_free);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : row_idx;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : x_row;
	assign mem_re    = (state_q == S_IDLE) && f2b.valid;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_row_q <= mem[row_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			sub_head_q  <= '0;
			out_valid_q <= 1'b0;
			mod_cnt_q   <= '0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			if (head_load.valid)
				sub_head_q <= head_load.value;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
					if (clr_cnt_q == ROW_AW'(ROWS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (f2b.valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						out_action_q <= x_action;
						out_id_q     <= item.id;
						out_status_q <= x_status;
						out_head_q   <= x_head;
						out_fwd_q    <= x_fwd;
						out_free_q   <= x_free;
						if (x_need_mod) begin
							// head lies beyond the size: fold it one bit per cycle
							mod_rem_q <= '0;
							mod_div_q <= head_inc;
							mod_cnt_q <= MOD_CNT_W'(QSIZE_W - 1);
							state_q   <= S_MOD;
						end else begin
							out_valid_q <= 1'b1;
							if (x_advance)
								sub_head_q <= x_head;
							state_q <= S_IDLE;
						end
					end
				end
				S_MOD: begin
					mod_rem_q <= rem_nx[QSIZE_W-1:0];
					mod_div_q <= {mod_div_q[QSIZE_W-2:0], 1'b0};
					if (mod_cnt_q == '0) begin
						out_head_q  <= rem_nx[HEAD_W-1:0];
						sub_head_q  <= rem_nx[HEAD_W-1:0];
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						mod_cnt_q <= mod_cnt_q - MOD_CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign b2f.pop       = (state_q == S_EXEC) && out_free;
	assign b2f.init_done = (state_q != S_CLEAR);

	assign out_ch.valid       = out_valid_q;
	assign out_ch.action      = out_action_q;
	assign out_ch.resp_id     = out_id_q;
	assign out_ch.resp_status = out_status_q;
	assign out_ch.resp_head   = out_head_q;
	assign out_ch.fwd_queue   = out_fwd_q;
	assign out_ch.id_was_free = out_free_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the queue command ID tracker
// Commands, completions and releases go in through a queued driver. Each
// one is run through a local copy of the busy bits, the submission head and
// the registers. Every result is checked field by field against the oldest
// pending outcome. The sequence is directed cases, then random traffic over
// several register settings, with random idle cycles and a long output
// stall in two of the phases.
// ----------------------------------------------------------------------------
module tb;
	import nqct_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int POOL_SIZE     = 32;

	typedef struct packed {
		action_t             action;
		logic [ID_W-1:0]     id;
		logic [STATUS_W-1:0] status;
		logic [HEAD_W-1:0]   head;
		logic [HEAD_W-1:0]   fwd;
		logic                was_free;
	} outcome_t;

	typedef struct {
		bit                 attached;
		bit                 link;
		bit                 admin;
		bit                 flow;
		logic [QSIZE_W-1:0] qsize;
		logic [HEAD_W-1:0]  qnum;
		bit                 load_head;
		logic [HEAD_W-1:0]  head;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [REG_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	nqct_in_if  cmd_ch();
	nqct_out_if res_ch();

	nvme_queue_cid_tracker u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (cmd_ch),
		.out_ch  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mirror of the tracker state
	bit                 id_busy [0:ID_SPACE-1];
	logic [HEAD_W-1:0]  sq_head;
	bit                 cfg_attached, cfg_link, cfg_admin, cfg_flow;
	logic [QSIZE_W-1:0] cfg_qsize;
	logic [HEAD_W-1:0]  cfg_qnum;

	item_t    pending_cmds [$];
	outcome_t outcomes_due [$];
	int       mismatches;
	int       src_idle_pct, snk_idle_pct;
	int       hold_asked, hold_given, hold_left;
	bit       cmd_taken;

	logic [ID_W-1:0] id_pool [POOL_SIZE];
	logic [ID_W-1:0] open_ids [$];

	always #6 clk = ~clk;

	task automatic note_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// put a status on the wire: response, or not-connected report
	function automatic void send_status(inout outcome_t o, input logic [STATUS_W-1:0] st);
		logic [31:0] wrap;
		o.status = st;
		if (!cfg_link) begin
			o.action = ACT_NOT_CONN;
			return;
		end
		o.action = ACT_RESP;
		if (cfg_flow) begin
			wrap = (cfg_qsize == '0) ? 32'd65536 : 32'(cfg_qsize);
			sq_head = 16'(({16'd0, sq_head} + 32'd1) % wrap);
			o.head = sq_head;
		end
	endfunction

	function automatic void track_command(input item_t it, output outcome_t o, output bit yields);
		o = '0;
		yields = 1'b0;
		if (it.op == OP_NONE)
			return;
		yields = 1'b1;
		o.id = it.id;
		o.action = ACT_DROP;
		if (it.op == OP_ARRIVE) begin
			if (!cfg_attached) begin
				o.action = ACT_DROP;
			end else if (it.check_code != '0) begin
				send_status(o, {SCT_GENERIC, it.check_code, 1'b0});
			end else if (id_busy[it.id]) begin
				send_status(o, {SCT_GENERIC, SC_ID_CONFLICT, 1'b0});
			end else begin
				id_busy[it.id] = 1'b1;
				if (cfg_admin) begin
					o.action = ACT_FWD_ADMIN;
				end else begin
					o.action = ACT_FWD_IO;
					o.fwd = cfg_qnum;
				end
			end
		end else begin
			// clear the bit whatever it held
			o.was_free = !id_busy[it.id];
			id_busy[it.id] = 1'b0;
			if (it.op == OP_COMPLETE)
				send_status(o, {it.status_type, it.status_value, 1'b0});
			else
				o.action = ACT_RELEASED;
		end
	endfunction

	// driver: advance to the next pending command once the current one is taken
	always @(negedge clk) begin : feed
		item_t nxt;
		if (!cmd_ch.valid || cmd_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = pending_cmds.pop_front();
				cmd_ch.opcode       <= nxt.op;
				cmd_ch.command_id   <= nxt.id;
				cmd_ch.check_code   <= nxt.check_code;
				cmd_ch.status_type  <= nxt.status_type;
				cmd_ch.status_value <= nxt.status_value;
				cmd_ch.valid        <= 1'b1;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// result sink: random stalls, plus long holds on request
	always @(negedge clk) begin
		if (hold_asked != hold_given) begin
			hold_left = HOLD_CYCLES;
			hold_given++;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// monitor: check results first, then predict the newly taken command
	always @(posedge clk) begin : watch
		outcome_t want;
		item_t    it;
		bit       yields;
		if (res_ch.valid && res_ch.ready) begin
			if (outcomes_due.size() == 0) begin
				note_mismatch("unexpected result id", res_ch.resp_id, 0);
			end else begin
				want = outcomes_due.pop_front();
				if (res_ch.action != want.action)
					note_mismatch("action", res_ch.action, want.action);
				if (res_ch.resp_id != want.id)
					note_mismatch("resp_id", res_ch.resp_id, want.id);
				if (res_ch.resp_status != want.status)
					note_mismatch("resp_status", res_ch.resp_status, want.status);
				if (res_ch.resp_head != want.head)
					note_mismatch("resp_head", res_ch.resp_head, want.head);
				if (res_ch.fwd_queue != want.fwd)
					note_mismatch("fwd_queue", res_ch.fwd_queue, want.fwd);
				if (res_ch.id_was_free != want.was_free)
					note_mismatch("id_was_free", res_ch.id_was_free, want.was_free);
			end
		end
		if (cmd_ch.valid && cmd_ch.ready) begin
			it.op           = op_t'(cmd_ch.opcode);
			it.id           = cmd_ch.command_id;
			it.check_code   = cmd_ch.check_code;
			it.status_type  = cmd_ch.status_type;
			it.status_value = cmd_ch.status_value;
			track_command(it, want, yields);
			if (yields)
				outcomes_due.push_back(want);
		end
		cmd_taken <= cmd_ch.valid && cmd_ch.ready;
	end

	task automatic set_register(input reg_idx_t idx, input logic [APB_DW-1:0] data);
		logic [APB_DW-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_CTRL:  cfg_attached = data[0];
			REG_LINK:  cfg_link     = data[0];
			REG_ADMIN: cfg_admin    = data[0];
			REG_FLOW:  cfg_flow     = data[0];
			REG_QSIZE: cfg_qsize    = data[QSIZE_W-1:0];
			REG_QNUM:  cfg_qnum     = data[HEAD_W-1:0];
			REG_HEAD:  sq_head      = data[HEAD_W-1:0];
			default: ;
		endcase
		// read it back
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		if (got != data)
			note_mismatch($sformatf("register %s readback", idx.name()), got, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_setting(input setting_t s);
		set_register(REG_CTRL,  32'(s.attached));
		set_register(REG_LINK,  32'(s.link));
		set_register(REG_ADMIN, 32'(s.admin));
		set_register(REG_FLOW,  32'(s.flow));
		set_register(REG_QSIZE, 32'(s.qsize));
		set_register(REG_QNUM,  32'(s.qnum));
		if (s.load_head)
			set_register(REG_HEAD, 32'(s.head));
	endtask

	task automatic add_cmd(input op_t op, input logic [ID_W-1:0] id, input logic [CHECK_W-1:0] chk,
			input logic [STYPE_W-1:0] st, input logic [SVAL_W-1:0] sv);
		item_t it;
		it.op           = op;
		it.id           = id;
		it.check_code   = chk;
		it.status_type  = st;
		it.status_value = sv;
		pending_cmds.push_back(it);
	endtask

	// hold until everything taken and answered, then let ignored commands settle
	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || cmd_ch.valid || outcomes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		if ($urandom_range(99) < 80)
			return id_pool[$urandom_range(POOL_SIZE-1)];
		return ID_W'($urandom);
	endfunction

	// mostly arrivals followed by their completion or release, plus noise
	task automatic add_random_traffic(input int n);
		int               roll, k;
		logic [ID_W-1:0]  id;
		logic [SVAL_W-1:0] sv;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			sv = ($urandom_range(99) < 30) ? '0 : SVAL_W'($urandom);
			if (roll < 45) begin
				id = pick_id();
				if ($urandom_range(9) == 0) begin
					add_cmd(OP_ARRIVE, id, CHECK_W'($urandom_range(255, 1)),
						STYPE_W'($urandom), sv);
				end else begin
					add_cmd(OP_ARRIVE, id, '0, STYPE_W'($urandom), sv);
					if (open_ids.size() < 64)
						open_ids.push_back(id);
				end
			end else if (roll < 93) begin
				if (open_ids.size() != 0 && $urandom_range(99) < 85) begin
					k = $urandom_range(open_ids.size() - 1);
					id = open_ids[k];
					open_ids.delete(k);
				end else begin
					id = pick_id();
				end
				add_cmd((roll < 75) ? OP_COMPLETE : OP_RELEASE, id, CHECK_W'($urandom),
					STYPE_W'($urandom), sv);
			end else begin
				add_cmd(OP_NONE, ID_W'($urandom), CHECK_W'($urandom), STYPE_W'($urandom),
					SVAL_W'($urandom));
			end
		end
	endtask

	task automatic run_phase(input setting_t s, input int n, input int src_pct,
			input int snk_pct, input bit hold);
		apply_setting(s);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		foreach (id_pool[i])
			id_pool[i] = ID_W'($urandom);
		id_pool[0] = '0;
		id_pool[1] = '1;
		open_ids.delete();
		if (hold)
			hold_asked++;
		add_random_traffic(n);
		wait_quiet();
	endtask

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.opcode       = '0;
		cmd_ch.command_id   = '0;
		cmd_ch.check_code   = '0;
		cmd_ch.status_type  = '0;
		cmd_ch.status_value = '0;
		res_ch.ready        = 1'b0;
		sq_head             = '0;
		cfg_attached        = 1'b0;
		cfg_link            = 1'b0;
		cfg_admin           = 1'b0;
		cfg_flow            = 1'b0;
		cfg_qsize           = 17'd1;
		cfg_qnum            = '0;
		src_idle_pct        = 17;
		snk_idle_pct        = 49;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: no controller, no link
		add_cmd(OP_ARRIVE, 16'h0000, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_COMPLETE, 16'hFFFF, 8'h00, 3'd7, 8'hFF);
		add_cmd(OP_RELEASE, 16'h1234, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_NONE, 16'hFFFF, 8'hFF, 3'd7, 8'hFF);
		wait_quiet();

		// I/O queue, tiny size, head loaded beyond it
		apply_setting('{1, 1, 0, 1, 17'd3, 16'hFFFF, 1, 16'hFFFF});
		add_cmd(OP_ARRIVE, 16'h0000, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_ARRIVE, 16'hFFFF, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_ARRIVE, 16'h0000, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_ARRIVE, 16'h0005, 8'hFF, 3'd0, 8'h00);
		add_cmd(OP_ARRIVE, 16'h0006, 8'h01, 3'd0, 8'h00);
		add_cmd(OP_COMPLETE, 16'h0000, 8'h00, 3'd7, 8'hFF);
		add_cmd(OP_COMPLETE, 16'h0000, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_COMPLETE, 16'hFFFF, 8'h00, 3'd5, 8'hAA);
		add_cmd(OP_RELEASE, 16'hFFFF, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_ARRIVE, 16'h0007, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_RELEASE, 16'h0007, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_NONE, 16'h0007, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_COMPLETE, 16'h0009, 8'h00, 3'd2, 8'h55);
		wait_quiet();

		// admin queue with the link down: conflict still reported
		apply_setting('{1, 0, 1, 0, 17'd0, 16'h1234, 0, 16'h0000});
		add_cmd(OP_ARRIVE, 16'h8000, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_ARRIVE, 16'h8000, 8'h00, 3'd0, 8'h00);
		add_cmd(OP_COMPLETE, 16'h8000, 8'h00, 3'd2, 8'h80);
		wait_quiet();

		run_phase('{1, 1, 0, 1, 17'd1, 16'h0000, 1, 16'h0000}, 200, 17, 49, 0);
		run_phase('{1, 1, 1, 1, 17'd65536, 16'hFFFF, 1, 16'hFFFE}, 200, 17, 49, 1);
		run_phase('{1, 1, 0, 1, 17'd0, 16'($urandom), 1, 16'hFFFF}, 200, 17, 49, 0);
		run_phase('{1, 1, 0, 1, 17'd5, 16'($urandom), 1, 16'd1000}, 200, 49, 17, 0);
		run_phase('{1, 0, 1, 1, 17'h1FFFF, 16'($urandom), 0, 16'h0000}, 200, 49, 17, 1);
		run_phase('{0, 1, 0, 1, 17'd7, 16'($urandom), 1, 16'd3}, 100, 49, 17, 0);
		run_phase('{1, 1, 0, 0, 17'd70000, 16'($urandom), 1, 16'hFFF0}, 200, 0, 0, 0);
		run_phase('{1, 1, 0, 1, 17'd70000, 16'h5A5A, 1, 16'hFFFD}, 200, 0, 0, 0);
		run_phase('{1, 1, 1, 1, 17'($urandom_range(64, 2)), 16'($urandom), 0, 16'h0000},
			200, 0, 0, 0);

		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
